/* hw/rtl/dsc_pkg.sv */
package dsc_pkg;

  // Input item kinds, as coded on the kind field.
  typedef enum logic [1:0] {
    KIND_HELD  = 2'd0,
    KIND_CLAIM = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_EVAL  = 2'd3
  } kind_t;

  // A classified item as it waits in the queue between front and back.
  typedef struct packed {
    kind_t      kind;
    logic       in_range;
    logic [2:0] process_slot;
    logic [1:0] resource_slot;
    logic [7:0] amount;
  } cmd_t;

endpackage

/* hw/rtl/dsc_if.sv */
interface dsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] process_slot;
  logic [1:0] resource_slot;
  logic [7:0] amount;

  modport source (output valid, kind, process_slot, resource_slot, amount, input ready);
  modport sink   (input valid, kind, process_slot, resource_slot, amount, output ready);
endinterface

interface dsc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_process;
  logic       blocked;
  logic       deadlocked;
  logic       last;

  modport source (output valid, result_process, blocked, deadlocked, last, input ready);
  modport sink   (input valid, result_process, blocked, deadlocked, last, output ready);
endinterface

/* hw/rtl/dsc_ram.sv */
module dsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/dsc_front.sv */
module dsc_front import dsc_pkg::*; #(
  parameter int PROCESS_COUNT  = 8,
  parameter int RESOURCE_COUNT = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accepting,
  dsc_in_if.sink   items,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_take
);

  cmd_t       incoming;
  logic       proc_ok;
  logic       res_ok;
  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  // Classify the beat: decide whether the addressed entry exists.
  always_comb begin
    proc_ok = int'(items.process_slot) < PROCESS_COUNT;
    res_ok  = int'(items.resource_slot) < RESOURCE_COUNT;
    incoming.kind          = kind_t'(items.kind);
    incoming.process_slot  = items.process_slot;
    incoming.resource_slot = items.resource_slot;
    incoming.amount        = items.amount;
    case (kind_t'(items.kind))
      KIND_HELD, KIND_CLAIM: incoming.in_range = proc_ok && res_ok;
      KIND_FREE:             incoming.in_range = res_ok;
      default:               incoming.in_range = 1'b1;
    endcase
  end

  assign items.ready = accepting && (count != 2'd2);
  assign push        = items.valid && items.ready;
  assign pop         = cmd_take && cmd_valid;
  assign cmd_valid   = count != 2'd0;
  assign cmd         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= incoming;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hw/rtl/dsc_back.sv */
module dsc_back import dsc_pkg::*; #(
  parameter int PROCESS_COUNT  = 8,
  parameter int RESOURCE_COUNT = 4,
  parameter int AMOUNT_BITS    = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  output logic      accepting,
  dsc_out_if.source results
);

  localparam int PB    = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
  localparam int RB    = (RESOURCE_COUNT > 1) ? $clog2(RESOURCE_COUNT) : 1;
  localparam int AW    = PB + RB;
  localparam int DEPTH = 1 << AW;
  localparam int WB    = AMOUNT_BITS + $clog2(PROCESS_COUNT + 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_READ  = 6'b001000,
    ST_LAST  = 6'b010000,
    ST_GRANT = 6'b100000
  } state_t;

  // While idle, the back end either takes commands or emits the results of
  // the evaluation that just finished.
  typedef enum logic [1:0] {
    PH_WORK = 2'b01,
    PH_EMIT = 2'b10
  } phase_t;

  state_t                 state;
  phase_t                 phase;
  logic [AW-1:0]          clr_addr;
  logic [PB-1:0]          p;
  logic [RB-1:0]          r;
  logic                   rd_valid;
  logic [RB-1:0]          rd_r;
  logic                   fits;
  logic                   granted;
  logic [AMOUNT_BITS-1:0] free_vec [RESOURCE_COUNT];
  logic [AMOUNT_BITS-1:0] row_buf  [RESOURCE_COUNT];
  logic [WB-1:0]          work     [RESOURCE_COUNT];
  logic [PROCESS_COUNT-1:0] done;

  logic                   out_valid;
  logic [2:0]             out_process;
  logic                   out_blocked;
  logic                   out_dead;
  logic                   out_last;

  logic                   clearing;
  logic                   held_we;
  logic                   claim_we;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic [AMOUNT_BITS-1:0] wdata;
  logic [AMOUNT_BITS-1:0] held_rdata;
  logic [AMOUNT_BITS-1:0] claim_rdata;
  logic [WB:0]            limit;
  logic                   over;
  logic                   last_r;
  logic                   last_p;
  logic                   emitting;
  logic                   emit_load;
  logic                   pass_grant;
  logic                   advance;

  assign clearing  = state == ST_CLEAR;
  assign accepting = !clearing;
  assign emitting  = (state == ST_IDLE) && (phase == PH_EMIT);
  assign cmd_take  = (state == ST_IDLE) && (phase == PH_WORK) && cmd_valid;

  assign held_we  = clearing || (cmd_take && cmd.kind == KIND_HELD && cmd.in_range);
  assign claim_we = clearing || (cmd_take && cmd.kind == KIND_CLAIM && cmd.in_range);
  assign waddr    = clearing ? clr_addr
                             : {PB'(cmd.process_slot), RB'(cmd.resource_slot)};
  assign wdata    = clearing ? '0 : AMOUNT_BITS'(cmd.amount);
  assign raddr    = {p, r};

  dsc_ram #(.WIDTH(AMOUNT_BITS), .DEPTH(DEPTH)) u_held (
    .clk   (clk),
    .we    (held_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (held_rdata)
  );

  dsc_ram #(.WIDTH(AMOUNT_BITS), .DEPTH(DEPTH)) u_claim (
    .clk   (clk),
    .we    (claim_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (claim_rdata)
  );

  // Need exceeds work exactly when claim > held + work; a claim below the
  // allocation can never pass that test.
  assign limit = (WB+1)'(work[rd_r]) + (WB+1)'(held_rdata);
  assign over  = (WB+1)'(claim_rdata) > limit;

  assign last_r     = r == RB'(RESOURCE_COUNT - 1);
  assign last_p     = p == PB'(PROCESS_COUNT - 1);
  assign emit_load  = emitting && (!out_valid || results.ready);
  assign pass_grant = granted || ((state == ST_GRANT) && fits);
  assign advance    = ((state == ST_SCAN) && done[p]) || (state == ST_GRANT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      phase     <= PH_WORK;
      clr_addr  <= '0;
      p         <= '0;
      r         <= '0;
      rd_valid  <= 1'b0;
      fits      <= 1'b1;
      granted   <= 1'b0;
      done      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < RESOURCE_COUNT; i++) begin
        free_vec[i] <= '0;
      end
    end else begin
      rd_valid <= state == ST_READ;
      rd_r     <= r;
      if (rd_valid) begin
        row_buf[rd_r] <= held_rdata;
        if (over) begin
          fits <= 1'b0;
        end
      end
      if (out_valid && results.ready && !emit_load) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (emit_load) begin
            out_valid   <= 1'b1;
            out_process <= 3'(p);
            out_blocked <= !done[p];
            out_dead    <= !(&done);
            out_last    <= last_p;
            if (last_p) begin
              phase <= PH_WORK;
              p     <= '0;
            end else begin
              p <= p + 1'b1;
            end
          end else if (cmd_take) begin
            if (cmd.kind == KIND_FREE && cmd.in_range) begin
              free_vec[RB'(cmd.resource_slot)] <= AMOUNT_BITS'(cmd.amount);
            end
            if (cmd.kind == KIND_EVAL) begin
              for (int i = 0; i < RESOURCE_COUNT; i++) begin
                work[i] <= WB'(free_vec[i]);
              end
              done    <= '0;
              p       <= '0;
              granted <= 1'b0;
              state   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!done[p]) begin
            r     <= '0;
            fits  <= 1'b1;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          r <= r + 1'b1;
          if (last_r) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          state <= ST_GRANT;
        end
        ST_GRANT: begin
          if (fits) begin
            for (int i = 0; i < RESOURCE_COUNT; i++) begin
              work[i] <= work[i] + WB'(row_buf[i]);
            end
            done[p] <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Step to the next process; at the end of a pass either start another
      // pass or, when nothing was granted, hand over to result emission.
      if (advance) begin
        if (last_p) begin
          p       <= '0;
          granted <= 1'b0;
          if (pass_grant) begin
            state <= ST_SCAN;
          end else begin
            state <= ST_IDLE;
            phase <= PH_EMIT;
          end
        end else begin
          p       <= p + 1'b1;
          granted <= pass_grant;
          state   <= ST_SCAN;
        end
      end
    end
  end

  assign results.valid          = out_valid;
  assign results.result_process = out_process;
  assign results.blocked        = out_blocked;
  assign results.deadlocked     = out_dead;
  assign results.last           = out_last;

  a_grant_marks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GRANT && fits) |=> done[$past(p)])
    else $error("granted process not marked done");

  a_tables_frozen: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_READ || state == ST_LAST || state == ST_GRANT ||
     emitting) |-> !(held_we || claim_we))
    else $error("table written during evaluation");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit_load && last_p) |=> (phase == PH_WORK && results.valid && results.last))
    else $error("final result did not close the evaluation");

endmodule

/* hw/rtl/deadlock_safety_check_top.sv */
// Channel   Port     Direction  Beat contents
// -------   -------  ---------  ---------------------------------------------
// input     items    sink       kind, process_slot, resource_slot, amount
// output    results  source     result_process, blocked, deadlocked, last
//
// A load beat (allocation, claim or available write) is taken once per cycle
// while the two-entry queue has room; the back end retires it when idle.
// For an evaluate beat, each pass visits every process; for each unfinished
// one it reads the table row and tries a grant. Passes repeat until one
// grants nothing, so there are at most PROCESS_COUNT + 1 passes. The table
// memory port reads one entry per cycle. Then PROCESS_COUNT result beats
// follow, one per cycle when results is ready.
// After reset a clearing pass zeroes all PB2 * RB2 entries of both tables,
// where PB2 and RB2 are PROCESS_COUNT and RESOURCE_COUNT rounded up to powers
// of two (32 entries at the defaults); items.ready stays low until it is done.
// A stall on results holds result emission and, with it, new commands; the
// queue keeps items flowing in until it fills.
module deadlock_safety_check_top import dsc_pkg::*; #(
  parameter int PROCESS_COUNT  = 8,
  parameter int RESOURCE_COUNT = 4,
  parameter int AMOUNT_BITS    = 8
) (
  input  logic      clk,
  input  logic      rst,
  dsc_in_if.sink    items,
  dsc_out_if.source results
);

  // Classified items waiting between the front and back ends.
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  logic accepting;

  // Front end: decodes each beat, checks its slots and queues it.
  dsc_front #(
    .PROCESS_COUNT  (PROCESS_COUNT),
    .RESOURCE_COUNT (RESOURCE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accepting (accepting),
    .items     (items),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // Back end: owns the tables, runs the safety passes and drives results.
  dsc_back #(
    .PROCESS_COUNT  (PROCESS_COUNT),
    .RESOURCE_COUNT (RESOURCE_COUNT),
    .AMOUNT_BITS    (AMOUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .accepting (accepting),
    .results   (results)
  );

  // No beat may enter while the tables are still being cleared.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    !accepting |-> !items.ready)
    else $error("item accepted during table clear");

endmodule

/* test/tb_top.sv */
module tb_top import dsc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PROCS = 8;
  localparam int RES   = 4;

  // Worst case for one evaluate beat: PROCS + 1 passes, each visiting every
  // process, then PROCS result beats, plus some margin.
  localparam int DRAIN_CYCLES = (PROCS + 1) * PROCS * (RES + 3) + PROCS + 16;

  // The receiver holds ready low for this many cycles once during the run.
  localparam int LONG_HOLD = 400;

  // Number of random beats in each of the three idling phases.
  localparam int PHASE_BEATS = 32;

  // One expected result beat: the verdict on one process.
  typedef struct {
    logic [2:0] process_id;
    logic       blocked;
    logic       deadlocked;
    logic       last;
  } verdict_t;

  // One row of the directed stimulus. Where typed is set, the blocked mask of
  // an evaluate row is the expected verdict instead of being predicted.
  typedef struct {
    kind_t      kind;
    logic [2:0] proc_slot;
    logic [1:0] res_slot;
    logic [7:0] amount;
    bit         typed;
    logic [7:0] blocked_mask;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  dsc_in_if  items_if ();
  dsc_out_if results_if ();

  deadlock_safety_check_top #(
    .PROCESS_COUNT  (PROCS),
    .RESOURCE_COUNT (RES),
    .AMOUNT_BITS    (8)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  always #5 clk = ~clk;

  // The testbench's own copy of the allocation table, the claim table and
  // the available vector. Only load beats change them.
  logic [7:0] held_units  [PROCS][RES];
  logic [7:0] claim_units [PROCS][RES];
  logic [7:0] free_units  [RES];

  verdict_t  pending_verdicts [$];
  stim_row_t directed_rows [$];

  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned hold_cycles    = 0;
  bit          hold_requested;
  bit          hold_started;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Runs the safety check over the current tables and returns a mask with
  // one bit set for every process that can never be granted. The passes
  // repeat until one of them grants nothing. A claim below the allocation
  // gives a need of zero, which always fits.
  function automatic logic [7:0] evaluate_safety();
    logic [11:0] work [RES];
    logic [7:0]  done;
    logic        granted;
    logic        fits;
    for (int r = 0; r < RES; r++) work[r] = {4'd0, free_units[r]};
    done = '0;
    for (int pass = 0; pass < PROCS; pass++) begin
      granted = 1'b0;
      for (int p = 0; p < PROCS; p++) begin
        if (!done[p]) begin
          fits = 1'b1;
          for (int r = 0; r < RES; r++) begin
            if (claim_units[p][r] > held_units[p][r] &&
                {4'd0, claim_units[p][r] - held_units[p][r]} > work[r])
              fits = 1'b0;
          end
          if (fits) begin
            done[p] = 1'b1;
            granted = 1'b1;
            for (int r = 0; r < RES; r++) work[r] += {4'd0, held_units[p][r]};
          end
        end
      end
      if (!granted) break;
    end
    return ~done;
  endfunction

  task automatic add_row(input kind_t k, input logic [2:0] p, input logic [1:0] r,
                         input logic [7:0] a, input bit typed, input logic [7:0] mask);
    stim_row_t row;
    row.kind = k;
    row.proc_slot = p;
    row.res_slot = r;
    row.amount = a;
    row.typed = typed;
    row.blocked_mask = mask;
    directed_rows.push_back(row);
  endtask

  // Offers one beat on the input channel, idling first at the sender's
  // current rate, and waits for it to be taken. On the accepting edge the
  // beat is applied to the local tables, and an evaluate beat queues one
  // verdict per process. The valid line is left high on return, so the next
  // call either keeps it high with a new payload or lowers it for a gap.
  task automatic send_beat(input kind_t k, input logic [2:0] p, input logic [1:0] r,
                           input logic [7:0] a, input bit typed,
                           input logic [7:0] typed_mask);
    logic [7:0] mask;
    verdict_t   v;
    while ($urandom_range(99) < send_idle_pct) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid         <= 1'b1;
    items_if.kind          <= k;
    items_if.process_slot  <= p;
    items_if.resource_slot <= r;
    items_if.amount        <= a;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    case (k)
      KIND_HELD:  held_units[p][r]  = a;
      KIND_CLAIM: claim_units[p][r] = a;
      KIND_FREE:  free_units[r]     = a;
      default: begin
        mask = typed ? typed_mask : evaluate_safety();
        for (int i = 0; i < PROCS; i++) begin
          v.process_id = i[2:0];
          v.blocked    = mask[i];
          v.deadlocked = |mask;
          v.last       = (i == PROCS - 1);
          pending_verdicts.push_back(v);
        end
      end
    endcase
  endtask

  // Receiver: random stalls at the current rate, or a long hold-off that is
  // counted down here, one cycle at a time.
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else if (hold_requested && !hold_started) begin
      results_if.ready <= 1'b0;
      hold_started     <= 1'b1;
      hold_cycles      <= LONG_HOLD - 1;
    end else if (hold_cycles != 0) begin
      results_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every accepted result beat is matched against the oldest verdict.
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result beat with nothing expected, process",
                        results_if.result_process, -1);
      end else begin
        want = pending_verdicts.pop_front();
        if (results_if.result_process !== want.process_id)
          report_mismatch("result_process", results_if.result_process, want.process_id);
        if (results_if.blocked !== want.blocked)
          report_mismatch($sformatf("blocked of process %0d", want.process_id),
                          results_if.blocked, want.blocked);
        if (results_if.deadlocked !== want.deadlocked)
          report_mismatch($sformatf("deadlocked of process %0d", want.process_id),
                          results_if.deadlocked, want.deadlocked);
        if (results_if.last !== want.last)
          report_mismatch($sformatf("last of process %0d", want.process_id),
                          results_if.last, want.last);
      end
    end
  end

  // Main stimulus.
  initial begin : stimulus
    int unsigned pick;
    kind_t       k;
    logic [7:0]  a;

    rst                    <= 1'b1;
    hold_requested         <= 1'b0;
    items_if.valid         <= 1'b0;
    items_if.kind          <= KIND_HELD;
    items_if.process_slot  <= '0;
    items_if.resource_slot <= '0;
    items_if.amount        <= '0;
    for (int p = 0; p < PROCS; p++)
      for (int r = 0; r < RES; r++) begin
        held_units[p][r]  = '0;
        claim_units[p][r] = '0;
      end
    for (int r = 0; r < RES; r++) free_units[r] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Straight after reset every table is zero, so every
    // need is zero and every process finishes.
    add_row(KIND_EVAL,  3'd0, 2'd0, 8'd0,   1, 8'h00);
    // The fields of an evaluate beat carry no meaning.
    add_row(KIND_EVAL,  3'd7, 2'd3, 8'd255, 1, 8'h00);
    // A full claim with nothing available blocks process 0 alone.
    add_row(KIND_CLAIM, 3'd0, 2'd0, 8'd255, 0, 8'h00);
    add_row(KIND_EVAL,  3'd0, 2'd0, 8'd0,   1, 8'h01);
    // The available write ignores its process slot; a full column frees it.
    add_row(KIND_FREE,  3'd5, 2'd0, 8'd255, 0, 8'h00);
    add_row(KIND_EVAL,  3'd0, 2'd0, 8'd0,   1, 8'h00);
    // Claim below allocation: the need counts as zero.
    add_row(KIND_HELD,  3'd7, 2'd3, 8'd255, 0, 8'h00);
    add_row(KIND_EVAL,  3'd0, 2'd0, 8'd0,   0, 8'h00);
    // Process 1 only fits once process 2 has handed back its units, which
    // takes a second pass.
    add_row(KIND_CLAIM, 3'd1, 2'd1, 8'd10,  0, 8'h00);
    add_row(KIND_FREE,  3'd0, 2'd1, 8'd5,   0, 8'h00);
    add_row(KIND_HELD,  3'd2, 2'd1, 8'd5,   0, 8'h00);
    add_row(KIND_CLAIM, 3'd2, 2'd1, 8'd5,   0, 8'h00);
    add_row(KIND_EVAL,  3'd0, 2'd0, 8'd0,   0, 8'h00);
    // Two processes that nothing can satisfy.
    add_row(KIND_CLAIM, 3'd4, 2'd2, 8'd255, 0, 8'h00);
    add_row(KIND_CLAIM, 3'd5, 2'd2, 8'd255, 0, 8'h00);
    add_row(KIND_FREE,  3'd0, 2'd2, 8'd0,   0, 8'h00);
    add_row(KIND_EVAL,  3'd0, 2'd0, 8'd0,   0, 8'h00);
    // Process 6 waits on units that process 7 returns.
    add_row(KIND_CLAIM, 3'd6, 2'd3, 8'd128, 0, 8'h00);
    add_row(KIND_FREE,  3'd0, 2'd3, 8'd127, 0, 8'h00);
    add_row(KIND_EVAL,  3'd0, 2'd0, 8'd0,   0, 8'h00);
    // Releasing process 4 and 5 leaves no deadlock.
    add_row(KIND_CLAIM, 3'd4, 2'd2, 8'd0,   0, 8'h00);
    add_row(KIND_HELD,  3'd5, 2'd2, 8'd255, 0, 8'h00);
    add_row(KIND_EVAL,  3'd0, 2'd0, 8'd0,   0, 8'h00);

    send_idle_pct = 33;
    recv_idle_pct = 47;
    foreach (directed_rows[i])
      send_beat(directed_rows[i].kind, directed_rows[i].proc_slot,
                directed_rows[i].res_slot, directed_rows[i].amount,
                directed_rows[i].typed, directed_rows[i].blocked_mask);

    // The sender pauses here until every verdict so far has come back.
    items_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);

    // Random part, in three idling phases. Most beats are loads with small
    // amounts so that needs and availability come close and both safe and
    // deadlocked states show up; extremes and the full range mix in.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 47;
          // Long receiver hold-off while the sender keeps offering beats:
          // the first evaluate stalls on the results, the queue fills and
          // the input is pushed back.
          hold_requested <= 1'b1;
          send_beat(KIND_EVAL, 3'd0, 2'd0, 8'd0, 0, 8'h00);
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      for (int n = 0; n < PHASE_BEATS; n++) begin
        pick = $urandom_range(99);
        if (pick < 35)      k = KIND_HELD;
        else if (pick < 70) k = KIND_CLAIM;
        else if (pick < 82) k = KIND_FREE;
        else                k = KIND_EVAL;
        pick = $urandom_range(99);
        if (pick < 45)      a = 8'($urandom_range(15));
        else if (pick < 55) a = 8'd0;
        else if (pick < 65) a = 8'd255;
        else                a = 8'($urandom_range(255));
        send_beat(k, 3'($urandom_range(PROCS - 1)), 2'($urandom_range(RES - 1)),
                  a, 0, 8'h00);
      end

      // Close each phase with an evaluation and let everything drain.
      send_beat(KIND_EVAL, 3'($urandom_range(7)), 2'($urandom_range(3)),
                8'($urandom_range(255)), 0, 8'h00);
      items_if.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clk);
    end

    items_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
